>>> hw/rtl/fixed_point_q24_8_alu_assert.svh
// Assertion macros used by the ALU back end.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FQA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Two signals never both high.
`define FQA_NEVER_BOTH(label, x, y) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !((x) && (y))) \
    else $error("mutually exclusive signals both high");

`endif

>>> hw/rtl/fqa_pkg.sv
package fqa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  // Dividend magnitude plus the fraction shift plus one bit for rounding.
  localparam int unsigned NumW     = DataW + FracBits + 1;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MIN = 3'd4,
    CMD_MAX = 3'd5,
    CMD_INC = 3'd6,
    CMD_DEC = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    logic               overflow;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_e              cmd;
    logic              neg;       // sign of the mul/div result
    logic [DataW-1:0]  mag_a;
    logic [DataW-1:0]  mag_b;
    logic [DataW-1:0]  simple;    // add, sub, min, max, inc or dec result
    logic              simple_ovf;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dbz;
  } work_t;

endpackage

>>> hw/rtl/fqa_front.sv
module fqa_front import fqa_pkg::*; (
  input  in_item_t item_i,
  output work_t    work_o
);

  logic signed [DataW:0] a_x, b_x, sum_x, dif_x, inc_x, dec_x;
  logic                  lt;

  always_comb begin
    a_x   = {item_i.operand_a[DataW-1], item_i.operand_a};
    b_x   = {item_i.operand_b[DataW-1], item_i.operand_b};
    sum_x = a_x + b_x;
    dif_x = a_x - b_x;
    inc_x = a_x + (DataW+1)'(1);
    dec_x = a_x - (DataW+1)'(1);
    lt    = item_i.operand_a < item_i.operand_b;

    work_o.cmd   = cmd_e'(item_i.cmd);
    work_o.neg   = item_i.operand_a[DataW-1] ^ item_i.operand_b[DataW-1];
    work_o.mag_a = item_i.operand_a[DataW-1] ? DataW'(-item_i.operand_a)
                                             : item_i.operand_a;
    work_o.mag_b = item_i.operand_b[DataW-1] ? DataW'(-item_i.operand_b)
                                             : item_i.operand_b;
    work_o.lt    = lt;
    work_o.eq    = item_i.operand_a == item_i.operand_b;
    work_o.gt    = item_i.operand_a > item_i.operand_b;
    work_o.dbz   = (cmd_e'(item_i.cmd) == CMD_DIV) && (item_i.operand_b == '0);
    work_o.simple     = '0;
    work_o.simple_ovf = 1'b0;
    unique case (cmd_e'(item_i.cmd))
      CMD_ADD: begin
        work_o.simple     = sum_x[DataW-1:0];
        work_o.simple_ovf = sum_x[DataW] ^ sum_x[DataW-1];
      end
      CMD_SUB: begin
        work_o.simple     = dif_x[DataW-1:0];
        work_o.simple_ovf = dif_x[DataW] ^ dif_x[DataW-1];
      end
      CMD_MIN: work_o.simple = lt ? item_i.operand_a : item_i.operand_b;
      CMD_MAX: work_o.simple = (item_i.operand_b > item_i.operand_a) ?
                               item_i.operand_b : item_i.operand_a;
      CMD_INC: begin
        work_o.simple     = inc_x[DataW-1:0];
        work_o.simple_ovf = inc_x[DataW] ^ inc_x[DataW-1];
      end
      CMD_DEC: begin
        work_o.simple     = dec_x[DataW-1:0];
        work_o.simple_ovf = dec_x[DataW] ^ dec_x[DataW-1];
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/fqa_queue.sv
module fqa_queue import fqa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  work_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output work_t data_o
);

  work_t      mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = cnt_q != 2'(QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/fqa_back.sv
// Operand stage with the multiply and the divide setup, then a 41-stage
// restoring divide pipeline, then rounding, sign and wrap into the output
// register.
module fqa_back import fqa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  work_t     work_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o
);

  `include "fixed_point_q24_8_alu_assert.svh"

  localparam int unsigned Stages = NumW;

  // The divide computes floor((2n + d) / 2d), n = |a| << FracBits.
  // Each pipeline stage resolves one quotient bit.
  typedef struct packed {
    work_t            w;
    logic [NumW-1:0]  num;
    logic [NumW-1:0]  rem;
    logic [NumW-1:0]  quo;
    logic [ProdW-1:0] prod;
  } stg_t;

  stg_t       s_q [Stages+1];
  logic       v_q [Stages+1];
  logic       adv;
  logic [NumW:0] dvs [Stages];
  out_item_t  o_q;
  logic       ov_q;

  function automatic logic [DataW:0] work_b2(logic [DataW-1:0] m);
    return {m, 1'b0};
  endfunction

  // Whole pipeline moves when the output register is empty or being read.
  assign adv     = !ov_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0].w    <= work_i;
      s_q[0].num  <= ({(NumW-DataW)'(0), work_i.mag_a} << (FracBits + 1))
                     + NumW'(work_i.mag_b);
      s_q[0].rem  <= '0;
      s_q[0].quo  <= '0;
      s_q[0].prod <= ProdW'(work_i.mag_a) * ProdW'(work_i.mag_b);
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_div
    logic [NumW:0] trial;
    assign dvs[i] = {(NumW+1-DataW-1)'(0), work_b2(s_q[i].w.mag_b)};
    assign trial  = {s_q[i].rem, s_q[i].num[NumW-1-i]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[i+1].w    <= s_q[i].w;
        s_q[i+1].num  <= s_q[i].num;
        s_q[i+1].prod <= s_q[i].prod;
        if (trial >= dvs[i]) begin
          s_q[i+1].rem <= NumW'(trial - dvs[i]);
          s_q[i+1].quo <= {s_q[i].quo[NumW-2:0], 1'b1};
        end else begin
          s_q[i+1].rem <= NumW'(trial);
          s_q[i+1].quo <= {s_q[i].quo[NumW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Stages; k++) v_q[k] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= Stages; k++) v_q[k] <= v_q[k-1];
      ov_q <= v_q[Stages];
    end
  end

  // Final rounding, sign and wrap.
  stg_t             f;
  logic [ProdW-1:0] pr;
  logic [ProdW-1:0] mag;
  logic [ProdW-1:0] sval;
  out_item_t        res;

  always_comb begin
    f   = s_q[Stages];
    pr  = (f.prod + ProdW'(1 << (FracBits - 1))) >> FracBits;
    mag = (f.w.cmd == CMD_MUL) ? pr : ProdW'(f.quo);
    sval = f.w.neg ? ProdW'(-mag) : mag;
    res.a_less         = f.w.lt;
    res.a_equal        = f.w.eq;
    res.a_greater      = f.w.gt;
    res.divide_by_zero = f.w.dbz;
    res.result_raw     = f.w.simple;
    res.overflow       = f.w.simple_ovf;
    if (f.w.cmd == CMD_MUL || f.w.cmd == CMD_DIV) begin
      res.result_raw = f.w.dbz ? '0 : sval[DataW-1:0];
      res.overflow   = !f.w.dbz &&
                       (sval[ProdW-1:DataW-1] != {(ProdW-DataW+1){sval[DataW-1]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) o_q <= res;
  end

  assign valid_o = ov_q;
  assign item_o  = o_q;

  `FQA_NEVER_BOTH(a_dbz_ovf, ov_q && o_q.divide_by_zero, o_q.overflow)
  `FQA_ASSERT(a_one_flag, ov_q |-> $countones({o_q.a_less, o_q.a_equal, o_q.a_greater}) == 1)
  `FQA_ASSERT(a_hold, (ov_q && !ready_i) |=> (ov_q && $stable(o_q)))

endmodule

>>> hw/rtl/fixed_point_q24_8_alu.sv
// Channel | Signals                             | Accepted when
// in      | in_valid_i, in_ready_o, in_item_i   | in_valid_i && in_ready_o
// out     | out_valid_o, out_ready_i, out_item_o| out_valid_o && out_ready_i
// One item per cycle sustained while the output is not stalled; each item passes
// through the queue, the operand stage, the divide pipeline (which every item goes
// through, so results stay in order) and the output register.
// Reset clears the queue and the pipeline valid bits; no clearing pass.
// A stall on the output freezes the back pipeline; the front keeps accepting
// until the two-entry queue is full.
module fixed_point_q24_8_alu import fqa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  work_t w_front, w_queue;
  logic  qv, qr;

  fqa_front u_front (.item_i(in_item_i), .work_o(w_front));

  fqa_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o), .data_i(w_front),
    .valid_o(qv), .ready_i(qr), .data_o(w_queue)
  );

  fqa_back u_back (
    .clk_i, .rst_ni,
    .valid_i(qv), .ready_o(qr), .work_i(w_queue),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .item_o(out_item_o)
  );

endmodule

>>> sim/fixed_point_q24_8_alu_checker.sv
module fixed_point_q24_8_alu_checker import fqa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t alu_results_q[$];

  function automatic out_item_t compute_alu(in_item_t it);
    out_item_t o;
    longint a, b, r;
    longint unsigned ma, mb, p, q, n;
    logic neg;
    a = longint'(it.operand_a);
    b = longint'(it.operand_b);
    r = 0;
    o = '0;
    ma = (a < 0) ? longint'(-a) : longint'(a);
    mb = (b < 0) ? longint'(-b) : longint'(b);
    neg = (a < 0) != (b < 0);
    case (cmd_e'(it.cmd))
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FracBits - 1))) >> FracBits;
        r = neg ? -longint'(q) : longint'(q);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r = 0;
          o.divide_by_zero = 1'b1;
        end else begin
          n = ma << FracBits;
          q = (2 * n + mb) / (2 * mb);
          r = neg ? -longint'(q) : longint'(q);
        end
      end
      CMD_MIN: r = (a < b) ? a : b;
      CMD_MAX: r = (b > a) ? b : a;
      CMD_INC: r = a + 1;
      default: r = a - 1;
    endcase
    o.result_raw = r[31:0];
    o.a_less = a < b;
    o.a_equal = a == b;
    o.a_greater = a > b;
    o.overflow = (r < -64'sd2147483648) || (r > 64'sd2147483647);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
      results_seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) alu_results_q.push_back(compute_alu(in_item_i));
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (alu_results_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = alu_results_q.pop_front();
          if (e !== out_item_i) fail_count_o <= fail_count_o + 1;
          if (e.result_raw !== out_item_i.result_raw)
            $error("result_raw: expected %0d actual %0d", e.result_raw, out_item_i.result_raw);
          if (e.a_less !== out_item_i.a_less)
            $error("a_less: expected %0d actual %0d", e.a_less, out_item_i.a_less);
          if (e.a_equal !== out_item_i.a_equal)
            $error("a_equal: expected %0d actual %0d", e.a_equal, out_item_i.a_equal);
          if (e.a_greater !== out_item_i.a_greater)
            $error("a_greater: expected %0d actual %0d", e.a_greater, out_item_i.a_greater);
          if (e.divide_by_zero !== out_item_i.divide_by_zero)
            $error("divide_by_zero: expected %0d actual %0d",
                   e.divide_by_zero, out_item_i.divide_by_zero);
          if (e.overflow !== out_item_i.overflow)
            $error("overflow: expected %0d actual %0d", e.overflow, out_item_i.overflow);
        end
      end
      pending_o <= alu_results_q.size();
    end
  end
endmodule

>>> sim/fixed_point_q24_8_alu_tb.sv
module fixed_point_q24_8_alu_tb;
  import fqa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 800;
  localparam int CycleLimit = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  int        fail_count;
  int        pending;
  int        results_seen;
  int        cycle_count = 0;
  int        sent;
  logic      calm = 1'b0;

  in_item_t  directed_q[$];

  fixed_point_q24_8_alu dut (.*);

  fixed_point_q24_8_alu_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return 32'($signed($urandom_range(0, 8192)) - 4096);
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t make_item(cmd_e c, logic [31:0] a, logic [31:0] b);
    in_item_t it;
    it.cmd = c;
    it.operand_a = a;
    it.operand_b = b;
    return it;
  endfunction

  // Idle about 14 percent of cycles, except during the calm stretch.
  always @(posedge clk_i) begin
    calm <= (cycle_count > 300) && (cycle_count < 600);
    if (rst_ni) out_ready_i <= calm || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic busy;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    sent = 0;
    for (int c = 0; c < 8; c++) begin
      directed_q.push_back(make_item(cmd_e'(c), 32'h7fff_ffff, 32'h7fff_ffff));
      directed_q.push_back(make_item(cmd_e'(c), 32'h8000_0000, 32'h8000_0000));
    end
    directed_q.push_back(make_item(CMD_DIV, 32'h0000_1234, 32'h0));
    directed_q.push_back(make_item(CMD_DIV, 32'h8000_0000, 32'h0000_0001));
    directed_q.push_back(make_item(CMD_DIV, 32'h0000_0001, 32'h0000_0002));
    directed_q.push_back(make_item(CMD_DIV, 32'hffff_ffff, 32'h0000_0002));
    directed_q.push_back(make_item(CMD_MUL, 32'h0000_0080, 32'h0000_0001));
    directed_q.push_back(make_item(CMD_MUL, 32'hffff_ff80, 32'h0000_0001));
    directed_q.push_back(make_item(CMD_MIN, 32'h0000_0005, 32'hffff_fffb));
    directed_q.push_back(make_item(CMD_MAX, 32'hffff_fffb, 32'h0000_0005));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < directed_q.size() + NumRandom) begin
      @(posedge clk_i);
      busy = in_valid_i && !in_ready_o;
      if (!busy) begin
        if (in_valid_i) sent++;
        if (sent < directed_q.size() + NumRandom && (calm || $urandom_range(0, 99) >= 14)) begin
          in_valid_i <= 1'b1;
          if (sent < directed_q.size()) in_item_i <= directed_q[sent];
          else in_item_i <= make_item(cmd_e'($urandom_range(0, 7)),
                                      rand_operand(), rand_operand());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items over all eight operations, checked %0d results.",
             sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
